FILE: rtl/lfsb_pkg.sv
// Shared types, constants and byte tables for the LCD frame byte sequencer.
package lfsb_pkg;

   // Frame geometry
   localparam int PANEL_COLS = 480;
   localparam int PANEL_ROWS = 320;
   localparam int BAND_ROWS  = 1;

   localparam int POS_W  = 9;
   localparam int PASS_W = 4;
   localparam int IDX_W  = 4;
   localparam int CNT_W  = 6;

   localparam logic [POS_W:0] WIDTH_C  = (POS_W + 1)'(PANEL_COLS);
   localparam logic [POS_W:0] HEIGHT_C = (POS_W + 1)'(PANEL_ROWS);
   localparam logic [POS_W:0] BAND_C   = (POS_W + 1)'(BAND_ROWS);

   localparam logic [PASS_W-1:0] PASS_COUNT_RESET = 4'd2;
   localparam logic [CNT_W-1:0]  MAX_BYTES        = 6'd26;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Panel command codes
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h29;
   localparam logic [7:0] CMD_COL_WINDOW  = 8'h2A;
   localparam logic [7:0] CMD_ROW_WINDOW  = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
   localparam logic [7:0] PAD_BYTE        = 8'h00;

   localparam logic [7:0] COL_END_HI = 8'((PANEL_COLS - 1) >> 8);
   localparam logic [7:0] COL_END_LO = 8'((PANEL_COLS - 1) & 255);

   // Segment lengths in bytes, minus one
   localparam logic [IDX_W-1:0] CMD_LAST_IDX   = 4'd1;
   localparam logic [IDX_W-1:0] CASET_LAST_IDX = 4'd9;
   localparam logic [IDX_W-1:0] RASET_LAST_IDX = 4'd11;

   typedef enum logic [6:0] {
      SEG_START  = 7'b0000001,
      SEG_ONPRE  = 7'b0000010,
      SEG_OFF    = 7'b0000100,
      SEG_CASET  = 7'b0001000,
      SEG_RASET  = 7'b0010000,
      SEG_PIX    = 7'b0100000,
      SEG_ONPOST = 7'b1000000
   } seg_type;

   // One pixel's work, classified by the front
   typedef struct packed {
      logic              on_pre;
      logic              frame_off;
      logic              frame_start;
      logic              band_start;
      logic              on_post;
      logic [15:0]       pix;
      logic [POS_W-1:0]  row_first;
      logic [POS_W-1:0]  row_end;
   } job_type;

   function automatic seg_type from_pix(job_type j);
      return j.on_post ? SEG_ONPOST : SEG_START;
   endfunction

   function automatic seg_type from_raset(job_type j);
      return j.band_start ? SEG_RASET : SEG_PIX;
   endfunction

   function automatic seg_type from_caset(job_type j);
      return j.frame_start ? SEG_CASET : from_raset(j);
   endfunction

   function automatic seg_type from_off(job_type j);
      return j.frame_off ? SEG_OFF : from_caset(j);
   endfunction

   // Next enabled segment after seg; SEG_START means the item is done
   function automatic seg_type next_seg(seg_type seg, job_type j);
      seg_type nxt;
      case (seg)
         SEG_START: begin
            nxt = j.on_pre ? SEG_ONPRE : from_off(j);
         end
         SEG_ONPRE:  nxt = from_off(j);
         SEG_OFF:    nxt = from_caset(j);
         SEG_CASET:  nxt = from_raset(j);
         SEG_RASET:  nxt = SEG_PIX;
         SEG_PIX:    nxt = from_pix(j);
         SEG_ONPOST: nxt = SEG_START;
         default:    nxt = SEG_START;
      endcase
      return nxt;
   endfunction

   function automatic logic [IDX_W-1:0] seg_last_idx(seg_type seg);
      logic [IDX_W-1:0] li;
      case (seg)
         SEG_CASET: li = CASET_LAST_IDX;
         SEG_RASET: li = RASET_LAST_IDX;
         default:   li = CMD_LAST_IDX;
      endcase
      return li;
   endfunction

   // Returns {data_not_command, byte}
   function automatic logic [8:0] seg_byte(seg_type seg, logic [IDX_W-1:0] idx, job_type j);
      logic [8:0] r;
      r = {1'b0, PAD_BYTE};
      case (seg)
         SEG_ONPRE, SEG_ONPOST: begin
            if (idx[0]) r = {1'b0, CMD_DISPLAY_ON};
         end
         SEG_OFF: begin
            if (idx[0]) r = {1'b0, CMD_DISPLAY_OFF};
         end
         SEG_CASET: begin
            case (idx)
               4'd0:    r = {1'b0, PAD_BYTE};
               4'd1:    r = {1'b0, CMD_COL_WINDOW};
               4'd7:    r = {1'b1, COL_END_HI};
               4'd9:    r = {1'b1, COL_END_LO};
               default: r = {1'b1, PAD_BYTE};
            endcase
         end
         SEG_RASET: begin
            case (idx)
               4'd0:    r = {1'b0, PAD_BYTE};
               4'd1:    r = {1'b0, CMD_ROW_WINDOW};
               4'd3:    r = {1'b1, 7'd0, j.row_first[POS_W-1]};
               4'd5:    r = {1'b1, j.row_first[7:0]};
               4'd7:    r = {1'b1, 7'd0, j.row_end[POS_W-1]};
               4'd9:    r = {1'b1, j.row_end[7:0]};
               4'd10:   r = {1'b0, PAD_BYTE};
               4'd11:   r = {1'b0, CMD_MEM_WRITE};
               default: r = {1'b1, PAD_BYTE};
            endcase
         end
         SEG_PIX: begin
            r = idx[0] ? {1'b1, j.pix[7:0]} : {1'b1, j.pix[15:8]};
         end
         default: r = {1'b0, PAD_BYTE};
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/lcd_frame_spi_byte_sequencer_top.sv
// Top level of the LCD frame byte sequencer: pixel stream in, panel byte stream out.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_blue, req_green, req_red
//   rsp       out   rsp_valid/rsp_ready    rsp_spi_byte, rsp_data_not_command, rsp_last
//   csr       in    csr_wr_en (no wait)    csr_pass_count
//
// Each pixel yields two bytes at one byte per cycle while the output is not
// stalled; the back end's byte sequencer sets that pace. A band start adds
// 12 command/parameter bytes, a frame start 10 more (12 on the first pass).
// Reset is synchronous, active high; pass_count resets to 2 and all
// counters to zero. A two-entry job queue lets the front keep taking
// pixels while the output register holds a stalled byte.
module lcd_frame_spi_byte_sequencer_top import lfsb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_red,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_spi_byte,
   output logic              rsp_data_not_command,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic [PASS_W-1:0] csr_pass_count
);

   logic [PASS_W-1:0] pass_count_ff, pass_count_in;

   logic    q_push, q_ready, q_pop, q_valid;
   job_type q_in_job, q_head_job;

   // Hold the pass count; a write lands at the next rising edge
   always_comb begin
      pass_count_in = csr_wr_en ? csr_pass_count : pass_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= PASS_COUNT_RESET;
      end else begin
         pass_count_ff <= pass_count_in;
      end
   end

   // Classify each pixel: which command bursts precede and follow it
   lfsb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .pass_count (pass_count_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_blue   (req_blue),
      .req_green  (req_green),
      .req_red    (req_red),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_job      (q_in_job)
   );

   // Decouple classification from byte emission
   lfsb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_in_job),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head_job)
   );

   // Emit bytes; drop the job once its last byte is loaded
   lfsb_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (q_valid),
      .head_job             (q_head_job),
      .pop                  (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_spi_byte         (rsp_spi_byte),
      .rsp_data_not_command (rsp_data_not_command),
      .rsp_last             (rsp_last)
   );

endmodule

FILE: rtl/lfsb_front.sv
// Front end: accepts pixels, tracks column, row, band and pass, classifies each item.
module lfsb_front import lfsb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [PASS_W-1:0] pass_count,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_red,
   input  logic              q_ready,
   output logic              q_push,
   output job_type           q_job
);

   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  band_ff, band_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              on_pend_ff, on_pend_in;

   logic [POS_W:0]    col_inc, row_inc, band_inc, row_sum;
   logic [PASS_W-1:0] passes;
   logic              col_end, row_end, pass_end, frame_done;
   logic              frame_start, frame_off, band_start, on_fits;
   logic [CNT_W-1:0]  n_pre;
   logic [POS_W-1:0]  row_end_val;

   always_comb begin
      col_inc  = {1'b0, col_ff} + 10'd1;
      row_inc  = {1'b0, row_ff} + 10'd1;
      band_inc = {1'b0, band_ff} + 10'd1;
      passes   = (pass_count == '0) ? 4'd1 : pass_count;
      col_end  = col_inc >= WIDTH_C;
      row_end  = row_inc >= HEIGHT_C;
      pass_end = ({1'b0, pass_ff} + 5'd1) >= {1'b0, passes};
      frame_done  = col_end && row_end && pass_end;
      frame_start = (col_ff == '0) && (row_ff == '0);
      frame_off   = frame_start && (pass_ff == '0);
      band_start  = (col_ff == '0) && (band_ff == '0);

      row_sum     = {1'b0, row_ff} + BAND_C;
      row_end_val = (row_sum > HEIGHT_C) ? POS_W'(HEIGHT_C - 10'd1)
                                         : POS_W'(row_sum - 10'd1);

      // Count the bytes ahead of the display-on command
      n_pre = 6'd2;
      if (on_pend_ff) n_pre = n_pre + 6'd2;
      if (frame_start) n_pre = n_pre + (frame_off ? 6'd12 : 6'd10);
      if (band_start) n_pre = n_pre + 6'd12;
      on_fits = (n_pre + 6'd2) <= MAX_BYTES;

      q_job.on_pre      = on_pend_ff;
      q_job.frame_off   = frame_off;
      q_job.frame_start = frame_start;
      q_job.band_start  = band_start;
      q_job.on_post     = frame_done && on_fits;
      q_job.pix         = {req_red[7:3], req_green[7:2], req_blue[7:3]};
      q_job.row_first   = row_ff;
      q_job.row_end     = row_end_val;

      req_ready = q_ready;
      q_push    = req_valid && q_ready;

      col_in     = col_ff;
      row_in     = row_ff;
      band_in    = band_ff;
      pass_in    = pass_ff;
      on_pend_in = on_pend_ff;
      if (q_push) begin
         on_pend_in = frame_done && !on_fits;
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in  = '0;
               band_in = '0;
               pass_in = pass_end ? '0 : PASS_W'(pass_ff + 4'd1);
            end else begin
               row_in  = POS_W'(row_inc);
               band_in = (band_inc >= BAND_C) ? '0 : POS_W'(band_inc);
            end
         end else begin
            col_in = POS_W'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         band_ff    <= '0;
         pass_ff    <= '0;
         on_pend_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         band_ff    <= band_in;
         pass_ff    <= pass_in;
         on_pend_ff <= on_pend_in;
      end
   end

   // A frame always opens a band
   a_frame_opens_band: assert property (@(posedge clock) disable iff (reset)
      (q_push && frame_start) |-> band_start)
      else $error("frame start without band start");

endmodule

FILE: rtl/lfsb_queue.sv
// Short job queue between the front and back ends.
module lfsb_queue import lfsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      push_ready = count_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_job   = mem_ff[rptr_ff];
      // Pointers wrap naturally; depth is a power of two
      wptr_in  = push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = pop  ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

FILE: rtl/lfsb_back.sv
// Back end: walks each job's command, parameter and pixel segments, one byte a cycle unless stalled.
module lfsb_back import lfsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_spi_byte,
   output logic       rsp_data_not_command,
   output logic       rsp_last
);

   seg_type          seg_ff, seg_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             dc_ff, dc_in;
   logic             last_ff, last_in;

   seg_type          cur_seg, nxt_seg;
   logic             load, seg_done;
   logic [8:0]       dc_byte;

   always_comb begin
      cur_seg  = (seg_ff == SEG_START) ? next_seg(SEG_START, head_job) : seg_ff;
      nxt_seg  = next_seg(cur_seg, head_job);
      seg_done = idx_ff == seg_last_idx(cur_seg);
      load     = head_valid && (!valid_ff || rsp_ready);
      pop      = load && seg_done && (nxt_seg == SEG_START);
      dc_byte  = seg_byte(cur_seg, idx_ff, head_job);

      valid_in = load || (valid_ff && !rsp_ready);
      byte_in  = byte_ff;
      dc_in    = dc_ff;
      last_in  = last_ff;
      seg_in   = seg_ff;
      idx_in   = idx_ff;
      if (load) begin
         byte_in = dc_byte[7:0];
         dc_in   = dc_byte[8];
         last_in = seg_done && (nxt_seg == SEG_START);
         if (seg_done) begin
            seg_in = nxt_seg;
            idx_in = '0;
         end else begin
            seg_in = cur_seg;
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_START;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      dc_ff   <= dc_in;
      last_ff <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_spi_byte         = byte_ff;
   assign rsp_data_not_command = dc_ff;
   assign rsp_last             = last_ff;

   a_seg_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(seg_ff))
      else $error("segment state not one-hot");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_last))
      else $error("item retired without last byte");

   a_idx_in_segment: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= seg_last_idx(cur_seg))
      else $error("byte index beyond segment");

endmodule
